/* rtl/core/wbpu_pkg.sv */
// Package with constants, types and codes shared by the warp brush pixel update block.
package wbpu_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_OFFSET   = 128;
    localparam int TAB_AW       = $clog2(TABLE_DEPTH);
    localparam int APB_AW       = 4;
    localparam int ONE_Q16      = 65536;
    localparam int STRENGTH_MAX = 25600;
    localparam int MAX_INFL     = 6553600;

    typedef enum logic [2:0] {
        MODE_MOVE   = 3'd0,
        MODE_GROW   = 3'd1,
        MODE_SHRINK = 3'd2,
        MODE_SWCW   = 3'd3,
        MODE_SWCCW  = 3'd4,
        MODE_ERASE  = 3'd5,
        MODE_SMOOTH = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        REG_STRENGTH = 2'd0,
        REG_SIZE     = 2'd1,
        REG_INV      = 2'd2,
        REG_MODE     = 2'd3
    } t_reg;

    typedef enum logic {
        CMD_TABLE = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_SET,
        OP_KEEP
    } t_op;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [8:0]  ox;
        logic signed [8:0]  oy;
    } t_pay;

endpackage

/* rtl/core/wbpu_if.sv */
// Stream interfaces for the pixel command beats and the result beats.
interface wbpu_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [7:0]         table_index;
    logic [16:0]        table_value;
    logic signed [8:0]  offset_x;
    logic signed [8:0]  offset_y;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;

    modport source (
        output valid, command, table_index, table_value, offset_x, offset_y,
               coord_x, coord_y, move_x, move_y, mean_x, mean_y,
        input  ready
    );
    modport sink (
        input  valid, command, table_index, table_value, offset_x, offset_y,
               coord_x, coord_y, move_x, move_y, mean_x, mean_y,
        output ready
    );
endinterface

interface wbpu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic [22:0]        influence_q16;

    modport source (output valid, new_x, new_y, influence_q16, input ready);
    modport sink   (input valid, new_x, new_y, influence_q16, output ready);
endinterface

/* rtl/core/warp_brush_pixel_update.sv */
// Each accepted pixel beat yields its result beat on the output register of stage 8.
// Throughput: one beat per cycle unless the output stalls; a table write beat takes one
// slot and gives no result. The rate is set by the nine-stage pipeline, which holds in
// place while the output stalls. Reset clears all valid bits and loads the configuration
// defaults. The falloff table is a memory whose contents are undefined until written.
module warp_brush_pixel_update (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wbpu_in_if.sink                     i_pix,
    wbpu_out_if.source                  o_res,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [wbpu_pkg::APB_AW-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready
);
    import wbpu_pkg::*;

    // Configuration registers.
    logic [14:0] r_strength;
    logic [8:0]  r_size;
    logic [24:0] r_inv;
    logic [2:0]  r_mode;
    logic        cfg_wr;
    t_reg        cfg_sel;

    assign o_pready = 1'b1;
    assign cfg_sel  = t_reg'(i_paddr[3:2]);
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= 15'd256;
            r_size     <= 9'd40;
            r_inv      <= 25'd419430;
            r_mode     <= MODE_MOVE;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_STRENGTH: r_strength <= i_pwdata[14:0];
                REG_SIZE:     r_size     <= i_pwdata[8:0];
                REG_INV:      r_inv      <= i_pwdata[24:0];
                REG_MODE:     r_mode     <= i_pwdata[2:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_STRENGTH: o_prdata = {17'd0, r_strength};
            REG_SIZE:     o_prdata = {23'd0, r_size};
            REG_INV:      o_prdata = {7'd0, r_inv};
            REG_MODE:     o_prdata = {29'd0, r_mode};
            default:      o_prdata = 32'd0;
        endcase
    end

    // Pipeline valid bits and stage enables.
    logic r_v1, r_v2a, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic en1, en2a, en2, en3, en4, en5, en6, en7, en8;

    assign en8  = !r_v8 || o_res.ready;
    assign en7  = !r_v7 || en8;
    assign en6  = !r_v6 || en7;
    assign en5  = !r_v5 || en6;
    assign en4  = !r_v4 || en5;
    assign en3  = !r_v3 || en4;
    assign en2  = !r_v2 || en3;
    assign en2a = !r_v2a || en2;
    assign en1  = !r_v1 || en2a;
    assign i_pix.ready = en1;

    // Stage 1: clamp offsets, squared radius, saturate the table value.
    logic               r_cmd1;
    logic [7:0]         r_idx1;
    logic [16:0]        r_tv1;
    logic [17:0]        r_r2_1;
    t_pay               r_p1;
    logic signed [8:0]  ox_c, oy_c;
    logic signed [18:0] r2_sum;

    always_comb begin
        ox_c = i_pix.offset_x;
        oy_c = i_pix.offset_y;
        if (int'(i_pix.offset_x) > MAX_OFFSET) ox_c = 9'(MAX_OFFSET);
        if (int'(i_pix.offset_x) < -MAX_OFFSET) ox_c = 9'(-MAX_OFFSET);
        if (int'(i_pix.offset_y) > MAX_OFFSET) oy_c = 9'(MAX_OFFSET);
        if (int'(i_pix.offset_y) < -MAX_OFFSET) oy_c = 9'(-MAX_OFFSET);
        r2_sum = 19'(ox_c) * 19'(ox_c) + 19'(oy_c) * 19'(oy_c);
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_cmd1 <= i_pix.command;
            r_idx1 <= i_pix.table_index;
            r_tv1  <= (i_pix.table_value > 17'(ONE_Q16)) ? 17'(ONE_Q16)
                                                          : i_pix.table_value;
            r_r2_1 <= r2_sum[17:0];
            r_p1   <= '{cx: i_pix.coord_x, cy: i_pix.coord_y,
                        mx: i_pix.move_x,  my: i_pix.move_y,
                        ax: i_pix.mean_x,  ay: i_pix.mean_y,
                        ox: ox_c, oy: oy_c};
        end
    end

    // Stage 2a: upper half of a bit-serial square root of 4*r2, brush limit test.
    logic               r_cmd2a, r_in2a;
    logic [7:0]         r_idx2a;
    logic [16:0]        r_tv2a;
    t_pay               r_p2a;
    logic [19:0]        r_sv2a, r_sr2a;
    logic [19:0]        sa_v, sa_r, sa_bit;
    logic [9:0]         lim;
    logic [19:0]        lim_sq;

    always_comb begin
        sa_v   = {r_r2_1, 2'b00};
        sa_r   = '0;
        sa_bit = 20'(1) << 18;
        for (int k = 0; k < 5; k++) begin
            if (sa_v >= sa_r + sa_bit) begin
                sa_v = sa_v - (sa_r + sa_bit);
                sa_r = (sa_r >> 1) + sa_bit;
            end else begin
                sa_r = sa_r >> 1;
            end
            sa_bit = sa_bit >> 2;
        end
        lim    = 10'(r_size) + 10'd2;
        lim_sq = 20'(lim) * 20'(lim);
    end

    always_ff @(posedge i_clk) begin
        if (en2a) begin
            r_cmd2a <= r_cmd1;
            r_idx2a <= r_idx1;
            r_tv2a  <= r_tv1;
            r_p2a   <= r_p1;
            r_sv2a  <= sa_v;
            r_sr2a  <= sa_r;
            r_in2a  <= ({r_r2_1, 2'b00} < lim_sq);
        end
    end

    // Stage 2: lower half of the square root and the rounded radius.
    logic              r_cmd2, r_wen2, r_in2;
    logic [TAB_AW-1:0] r_addr2;
    logic [16:0]       r_tv2;
    t_pay              r_p2;
    logic [19:0]       sq_v, sq_r, sq_bit;
    logic [31:0]       n32, idx32;

    always_comb begin
        sq_v   = r_sv2a;
        sq_r   = r_sr2a;
        sq_bit = 20'(1) << 8;
        for (int k = 0; k < 5; k++) begin
            if (sq_v >= sq_r + sq_bit) begin
                sq_v = sq_v - (sq_r + sq_bit);
                sq_r = (sq_r >> 1) + sq_bit;
            end else begin
                sq_r = sq_r >> 1;
            end
            sq_bit = sq_bit >> 2;
        end
        // The square root of 4*r2 is twice the radius; adding one and halving rounds it.
        n32 = 32'((sq_r + 20'd1) >> 1);
        if (n32 > 32'(TABLE_DEPTH - 1)) n32 = 32'(TABLE_DEPTH - 1);
        idx32 = 32'(r_idx2a);
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_cmd2  <= r_cmd2a;
            r_wen2  <= (idx32 < 32'(TABLE_DEPTH));
            r_addr2 <= (r_cmd2a == CMD_PIXEL) ? n32[TAB_AW-1:0] : idx32[TAB_AW-1:0];
            r_in2   <= r_in2a;
            r_tv2   <= r_tv2a;
            r_p2    <= r_p2a;
        end
    end

    // Stage 3: falloff table, written and read in beat order.
    logic [16:0] mem [TABLE_DEPTH];
    logic [16:0] r_tab3;
    logic        r_in3;
    t_pay        r_p3;

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2 && r_cmd2 == CMD_TABLE && r_wen2) begin
            mem[r_addr2] <= r_tv2;
        end
        if (en3) begin
            r_tab3 <= mem[r_addr2];
            r_in3  <= r_in2;
            r_p3   <= r_p2;
        end
    end

    // Stage 4: influence = strength times falloff, rounded to Q7.16.
    logic [14:0] st;
    logic [31:0] infl_prod;
    logic [22:0] r_infl4;
    t_pay        r_p4;

    always_comb begin
        st = (r_strength > 15'(STRENGTH_MAX)) ? 15'(STRENGTH_MAX) : r_strength;
        infl_prod = 32'(st) * 32'(r_tab3) + 32'd128;
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_infl4 <= r_in3 ? infl_prod[30:8] : 23'd0;
            r_p4    <= r_p3;
        end
    end

    // Stage 5: per-lane multiplier operands and the final operation.
    logic signed [32:0] r_a5 [2];
    logic signed [25:0] r_b5 [2];
    t_op                r_op5 [2];
    logic               r_sh5;
    logic [22:0]        r_infl5;
    logic signed [31:0] r_c5 [2];
    logic signed [8:0]  off_sel [2];
    logic signed [32:0] io_prod [2];
    logic signed [32:0] diff [2];
    logic signed [25:0] infl_s, inv_s, fac_s;
    logic               swirl;
    t_mode              mode;
    t_op                op_n [2];
    logic signed [32:0] a_n [2];
    logic signed [25:0] b_n [2];

    always_comb begin
        mode    = t_mode'(r_mode);
        swirl   = (mode == MODE_SWCW) || (mode == MODE_SWCCW);
        infl_s  = $signed({3'b000, r_infl4});
        inv_s   = $signed({1'b0, r_inv});
        fac_s   = (r_infl4 > 23'(ONE_Q16)) ? 26'sd0
                                          : 26'sd65536 - infl_s;
        off_sel[0] = swirl ? r_p4.oy : r_p4.ox;
        off_sel[1] = swirl ? r_p4.ox : r_p4.oy;
        diff[0]    = 33'(r_p4.cx) - 33'(r_p4.ax);
        diff[1]    = 33'(r_p4.cy) - 33'(r_p4.ay);
        for (int l = 0; l < 2; l++) begin
            io_prod[l] = 33'(infl_s) * 33'(off_sel[l]);
        end
        for (int l = 0; l < 2; l++) begin
            case (mode)
                MODE_MOVE: begin
                    a_n[l] = (l == 0) ? 33'(r_p4.mx) : 33'(r_p4.my);
                    b_n[l] = infl_s;
                    op_n[l] = OP_ADD;
                end
                MODE_GROW, MODE_SHRINK, MODE_SWCW, MODE_SWCCW: begin
                    a_n[l] = io_prod[l];
                    b_n[l] = inv_s;
                    op_n[l] = OP_ADD;
                    if (mode == MODE_GROW) op_n[l] = OP_SUB;
                    if (mode == MODE_SWCW && l == 1) op_n[l] = OP_SUB;
                    if (mode == MODE_SWCCW && l == 0) op_n[l] = OP_SUB;
                end
                MODE_ERASE: begin
                    a_n[l] = (l == 0) ? 33'(r_p4.cx) : 33'(r_p4.cy);
                    b_n[l] = fac_s;
                    op_n[l] = OP_SET;
                end
                MODE_SMOOTH: begin
                    a_n[l] = diff[l];
                    b_n[l] = infl_s;
                    op_n[l] = OP_SUB;
                end
                default: begin
                    a_n[l] = '0;
                    b_n[l] = '0;
                    op_n[l] = OP_KEEP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            for (int l = 0; l < 2; l++) begin
                r_a5[l]  <= a_n[l];
                r_b5[l]  <= b_n[l];
                r_op5[l] <= op_n[l];
            end
            r_sh5   <= swirl || (mode == MODE_GROW) || (mode == MODE_SHRINK);
            r_infl5 <= r_infl4;
            r_c5[0] <= r_p4.cx;
            r_c5[1] <= r_p4.cy;
        end
    end

    // Stage 6: the wide products.
    logic signed [58:0] r_p6 [2];
    t_op                r_op6 [2];
    logic               r_sh6;
    logic [22:0]        r_infl6;
    logic signed [31:0] r_c6 [2];

    always_ff @(posedge i_clk) begin
        if (en6) begin
            for (int l = 0; l < 2; l++) begin
                r_p6[l]  <= 59'(r_a5[l]) * 59'(r_b5[l]);
                r_op6[l] <= r_op5[l];
                r_c6[l]  <= r_c5[l];
            end
            r_sh6   <= r_sh5;
            r_infl6 <= r_infl5;
        end
    end

    // Stage 7: round to nearest, ties toward plus infinity.
    logic signed [59:0] r_t7 [2];
    t_op                r_op7 [2];
    logic [22:0]        r_infl7;
    logic signed [31:0] r_c7 [2];
    logic signed [59:0] rnd [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            rnd[l] = 60'(r_p6[l]) + (r_sh6 ? 60'sd8388608 : 60'sd32768);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            for (int l = 0; l < 2; l++) begin
                r_t7[l]  <= r_sh6 ? (rnd[l] >>> 24) : (rnd[l] >>> 16);
                r_op7[l] <= r_op6[l];
                r_c7[l]  <= r_c6[l];
            end
            r_infl7 <= r_infl6;
        end
    end

    // Stage 8: apply to the coordinate and saturate into the output register.
    logic signed [60:0] sum [2];
    logic signed [31:0] sat [2];
    logic signed [31:0] r_nx, r_ny;
    logic [22:0]        r_infl8;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            case (r_op7[l])
                OP_ADD:  sum[l] = 61'(r_c7[l]) + 61'(r_t7[l]);
                OP_SUB:  sum[l] = 61'(r_c7[l]) - 61'(r_t7[l]);
                OP_SET:  sum[l] = 61'(r_t7[l]);
                default: sum[l] = 61'(r_c7[l]);
            endcase
            if (sum[l] > 61'sd2147483647) begin
                sat[l] = 32'sh7FFFFFFF;
            end else if (sum[l] < -61'sd2147483648) begin
                sat[l] = 32'sh80000000;
            end else begin
                sat[l] = sum[l][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en8) begin
            r_nx    <= sat[0];
            r_ny    <= sat[1];
            r_infl8 <= r_infl7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2a <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
        end else begin
            if (en1)  r_v1  <= i_pix.valid;
            if (en2a) r_v2a <= r_v1;
            if (en2)  r_v2  <= r_v2a;
            // A table write beat ends here and leaves no result.
            if (en3) r_v3 <= r_v2 && (r_cmd2 == CMD_PIXEL);
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
            if (en7) r_v7 <= r_v6;
            if (en8) r_v8 <= r_v7;
        end
    end

    assign o_res.valid         = r_v8;
    assign o_res.new_x         = r_nx;
    assign o_res.new_y         = r_ny;
    assign o_res.influence_q16 = r_infl8;

    // Checks.
    a_infl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (32'(o_res.influence_q16) <= 32'(MAX_INFL)))
        else $error("influence above full strength");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_v7))
        else $error("result beat appeared without a beat in the last stage");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

endmodule

/* tb/sv/warp_brush_pixel_update_tb.sv */
// Self-checking testbench for the warp brush pixel update block.
module warp_brush_pixel_update_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wbpu_pkg::*;

    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        t_cmd               command;
        logic [7:0]         table_index;
        logic [16:0]        table_value;
        logic signed [8:0]  offset_x;
        logic signed [8:0]  offset_y;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
    } pixel_beat_t;

    typedef struct {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic [22:0]        influence_q16;
    } update_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_psel = 1'b0;
    logic i_penable = 1'b0;
    logic i_pwrite = 1'b0;
    logic [APB_AW-1:0] i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic o_pready;

    wbpu_in_if  pix_if ();
    wbpu_out_if res_if ();

    warp_brush_pixel_update DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix_if.sink),
        .o_res     (res_if.source),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the block's state.
    logic [16:0] falloff_lut [TABLE_DEPTH];
    logic [14:0] strength_reg = 15'd256;
    logic [8:0]  size_reg = 9'd40;
    logic [24:0] inv_size_reg = 25'd419430;
    logic [2:0]  mode_reg = MODE_MOVE;

    update_t pending_updates [$];
    int src_idle = 0;
    int snk_idle = 0;
    int error_count = 0;

    initial begin
        pix_if.valid = 1'b0;
        pix_if.command = CMD_TABLE;
        pix_if.table_index = '0;
        pix_if.table_value = '0;
        pix_if.offset_x = '0;
        pix_if.offset_y = '0;
        pix_if.coord_x = '0;
        pix_if.coord_y = '0;
        pix_if.move_x = '0;
        pix_if.move_y = '0;
        pix_if.mean_x = '0;
        pix_if.mean_y = '0;
        res_if.ready = 1'b0;
    end

    function automatic longint round_q(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint clamp_offset(logic signed [8:0] v);
        longint w;
        w = v;
        if (w > MAX_OFFSET) return MAX_OFFSET;
        if (w < -MAX_OFFSET) return -MAX_OFFSET;
        return w;
    endfunction

    function automatic update_t predict_update(pixel_beat_t p);
        update_t u;
        longint ox, oy, cx, cy, mx, my, ax, ay, nx, ny, infl, inv, r2, n, lim, st, fade;
        ox = clamp_offset(p.offset_x);
        oy = clamp_offset(p.offset_y);
        cx = p.coord_x;
        cy = p.coord_y;
        mx = p.move_x;
        my = p.move_y;
        ax = p.mean_x;
        ay = p.mean_y;
        r2 = ox * ox + oy * oy;
        lim = longint'(size_reg) + 2;
        infl = 0;
        if (4 * r2 < lim * lim) begin
            n = 0;
            while ((n + 1) * (n + 1) <= r2) n++;
            if (r2 > n * n + n) n++;
            if (n > TABLE_DEPTH - 1) n = TABLE_DEPTH - 1;
            st = (strength_reg > STRENGTH_MAX) ? STRENGTH_MAX : strength_reg;
            infl = (st * longint'(falloff_lut[n]) + 128) >>> 8;
        end
        inv = inv_size_reg;
        nx = cx;
        ny = cy;
        case (mode_reg)
            MODE_MOVE: begin
                nx = cx + round_q(infl * mx, 16);
                ny = cy + round_q(infl * my, 16);
            end
            MODE_GROW: begin
                nx = cx - round_q(infl * ox * inv, 24);
                ny = cy - round_q(infl * oy * inv, 24);
            end
            MODE_SHRINK: begin
                nx = cx + round_q(infl * ox * inv, 24);
                ny = cy + round_q(infl * oy * inv, 24);
            end
            MODE_SWCW: begin
                nx = cx + round_q(infl * oy * inv, 24);
                ny = cy - round_q(infl * ox * inv, 24);
            end
            MODE_SWCCW: begin
                nx = cx - round_q(infl * oy * inv, 24);
                ny = cy + round_q(infl * ox * inv, 24);
            end
            MODE_ERASE: begin
                fade = ONE_Q16 - ((infl > ONE_Q16) ? ONE_Q16 : infl);
                nx = round_q(cx * fade, 16);
                ny = round_q(cy * fade, 16);
            end
            MODE_SMOOTH: begin
                nx = cx - round_q(infl * (cx - ax), 16);
                ny = cy - round_q(infl * (cy - ay), 16);
            end
            default: ;
        endcase
        u.new_x = sat32(nx);
        u.new_y = sat32(ny);
        u.influence_q16 = infl[22:0];
        return u;
    endfunction

    // Result ready is drawn at random on each falling edge.
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge i_clk) begin
        update_t exp_u;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected result beat x=%h y=%h infl=%h", $time,
                         res_if.new_x, res_if.new_y, res_if.influence_q16);
                error_count++;
            end else begin
                exp_u = pending_updates.pop_front();
                if (res_if.new_x !== exp_u.new_x) begin
                    $display("%0t: new_x expected %h actual %h", $time,
                             exp_u.new_x, res_if.new_x);
                    error_count++;
                end
                if (res_if.new_y !== exp_u.new_y) begin
                    $display("%0t: new_y expected %h actual %h", $time,
                             exp_u.new_y, res_if.new_y);
                    error_count++;
                end
                if (res_if.influence_q16 !== exp_u.influence_q16) begin
                    $display("%0t: influence_q16 expected %h actual %h", $time,
                             exp_u.influence_q16, res_if.influence_q16);
                    error_count++;
                end
            end
        end
    end

    task automatic send_beat(pixel_beat_t p);
        while ($urandom_range(99) < src_idle) begin
            @(negedge i_clk);
            pix_if.valid = 1'b0;
        end
        @(negedge i_clk);
        pix_if.valid = 1'b1;
        pix_if.command = p.command;
        pix_if.table_index = p.table_index;
        pix_if.table_value = p.table_value;
        pix_if.offset_x = p.offset_x;
        pix_if.offset_y = p.offset_y;
        pix_if.coord_x = p.coord_x;
        pix_if.coord_y = p.coord_y;
        pix_if.move_x = p.move_x;
        pix_if.move_y = p.move_y;
        pix_if.mean_x = p.mean_x;
        pix_if.mean_y = p.mean_y;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        // The prediction uses the table and registers as they stand at acceptance.
        if (p.command == CMD_TABLE)
            falloff_lut[p.table_index] = (p.table_value > 17'(ONE_Q16)) ? 17'(ONE_Q16)
                                                                         : p.table_value;
        else
            pending_updates.push_back(predict_update(p));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        pix_if.valid = 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [31:0] data);
        wait_idle();
        @(negedge i_clk);
        i_psel = 1'b1;
        i_pwrite = 1'b1;
        i_penable = 1'b0;
        i_paddr = {idx, 2'b00};
        i_pwdata = data;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        case (idx)
            REG_STRENGTH: strength_reg = data[14:0];
            REG_SIZE:     size_reg = data[8:0];
            REG_INV:      inv_size_reg = data[24:0];
            REG_MODE:     mode_reg = data[2:0];
            default:      ;
        endcase
        @(negedge i_clk);
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
    endtask

    task automatic configure(logic [31:0] st, logic [31:0] sz, logic [31:0] inv,
                             logic [31:0] md);
        write_reg(REG_STRENGTH, st);
        write_reg(REG_SIZE, sz);
        write_reg(REG_INV, inv);
        write_reg(REG_MODE, md);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(2097152)) - 32'sd1048576;
        endcase
    endfunction

    function automatic pixel_beat_t table_beat(logic [7:0] idx, logic [16:0] val);
        pixel_beat_t p;
        p.command = CMD_TABLE;
        p.table_index = idx;
        p.table_value = val;
        p.offset_x = 9'($urandom);
        p.offset_y = '0;
        p.coord_x = $urandom;
        p.coord_y = '0;
        p.move_x = '0;
        p.move_y = '0;
        p.mean_x = '0;
        p.mean_y = '0;
        return p;
    endfunction

    function automatic pixel_beat_t pixel_beat(int reach);
        pixel_beat_t p;
        p.command = CMD_PIXEL;
        p.table_index = 8'($urandom);
        p.table_value = 17'($urandom);
        if ($urandom_range(9) == 0) begin
            p.offset_x = 9'($urandom);
            p.offset_y = 9'($urandom);
        end else begin
            p.offset_x = 9'($signed($urandom_range(2 * reach)) - reach);
            p.offset_y = 9'($signed($urandom_range(2 * reach)) - reach);
        end
        p.coord_x = rand_coord();
        p.coord_y = rand_coord();
        p.move_x = rand_coord();
        p.move_y = rand_coord();
        p.mean_x = ($urandom_range(1)) ? rand_coord() : p.coord_x + $signed($urandom_range(4095));
        p.mean_y = rand_coord();
        return p;
    endfunction

    // Every entry is written before any pixel can read it.
    task automatic test_table_load();
        send_beat(table_beat(8'd0, 17'd65536));
        send_beat(table_beat(8'd255, 17'h1FFFF));
        send_beat(table_beat(8'd1, 17'd0));
        for (int i = 2; i < TABLE_DEPTH - 1; i++)
            send_beat(table_beat(i[7:0], 17'($urandom_range(ONE_Q16 + 3000))));
    endtask

    task automatic test_directed_modes();
        pixel_beat_t p;
        for (int m = 0; m < 8; m++) begin
            configure(STRENGTH_MAX, 40, 419430, m);
            p = pixel_beat(20);
            p.offset_x = 9'sd0;
            p.offset_y = 9'sd0;
            send_beat(p);
            p = pixel_beat(20);
            p.offset_x = -9'sd256;
            p.offset_y = 9'sd255;
            send_beat(p);
            p = pixel_beat(20);
            p.offset_x = 9'sd3;
            p.offset_y = -9'sd4;
            p.coord_x = 32'h7FFFFFFF;
            p.coord_y = 32'h80000000;
            p.move_x = 32'h7FFFFFFF;
            p.move_y = 32'h80000000;
            p.mean_x = 32'h80000000;
            p.mean_y = 32'h7FFFFFFF;
            send_beat(p);
        end
        // Oversized strength, widest brush and largest reciprocal.
        configure(32'h7FFF, 32'h1FF, 32'h1FFFFFF, 32'(MODE_SWCW));
        send_beat(pixel_beat(255));
        send_beat(pixel_beat(255));
        // Tiny brush with zero strength: only offsets within one step of the centre fall inside.
        configure(0, 1, 65536, 32'(MODE_MOVE));
        send_beat(pixel_beat(2));
        send_beat(pixel_beat(2));
        // A table word at the tail index is rewritten mid-stream.
        send_beat(table_beat(8'd255, 17'd40000));
    endtask

    task automatic test_random_phase(int n_items, int s_idle, int r_idle);
        int reach;
        src_idle = s_idle;
        snk_idle = r_idle;
        for (int i = 0; i < n_items; i++) begin
            if (i % 80 == 0) begin
                case ($urandom_range(3))
                    0: configure(STRENGTH_MAX, 32'h1FF, 32'h1FFFFFF, $urandom_range(7));
                    1: configure(0, 1, 0, $urandom_range(7));
                    default: configure($urandom_range(32767), $urandom_range(1, 300),
                                       $urandom_range(65536, 16777216), $urandom_range(7));
                endcase
            end
            reach = size_reg / 2 + 3;
            if (reach > 255) reach = 255;
            if ($urandom_range(9) == 0)
                send_beat(table_beat(8'($urandom), 17'($urandom)));
            else
                send_beat(pixel_beat(reach));
        end
    endtask

    // The sender holds back until the pipeline has fully drained, then resumes.
    task automatic test_drain_pause();
        for (int k = 0; k < 3; k++) begin
            repeat (8) send_beat(pixel_beat(20));
            @(negedge i_clk);
            pix_if.valid = 1'b0;
            while (pending_updates.size() != 0) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_table_load();
        test_directed_modes();
        test_random_phase(430, 12, 76);
        test_drain_pause();
        test_random_phase(430, 76, 12);
        test_random_phase(430, 0, 0);
        wait_idle();
        if (error_count == 0)
            $display("warp_brush_pixel_update_tb: clean");
        else
            $display("warp_brush_pixel_update_tb: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("warp_brush_pixel_update_tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/wbpu_pkg.sv
rtl/core/wbpu_if.sv
rtl/core/warp_brush_pixel_update.sv
tb/sv/warp_brush_pixel_update_tb.sv
